// ----- hdl/rcct_pkg.sv -----
// Shared types and constants of the ray cell travel time block.
package rcct_pkg;

  localparam int unsigned SLOW_BITS = 32;
  localparam int unsigned TIME_BITS = 48;
  localparam int unsigned STAT_BITS = 2;

  typedef enum logic [1:0] {
    KIND_VERT  = 2'd0,
    KIND_HORZ  = 2'd1,
    KIND_SLOPE = 2'd2
  } kind_e;

  typedef enum logic [STAT_BITS-1:0] {
    ST_HIT   = 2'd0,
    ST_MISS  = 2'd1,
    ST_AMBIG = 2'd2
  } status_e;

  // Classification that the front attaches to every cell word
  typedef struct packed {
    kind_e kind;
    logic  outside;
  } front_ctl_t;

endpackage

// ----- hdl/ray_cell_travel_time.sv -----
// Top level of the straight ray cell travel time block.
//
// Each input word carries one rectangular cell, its slowness and one straight
// ray; each yields exactly one result word with the travel time inside the
// cell (unsigned Q24.24, saturating) and a status of hit, miss or ambiguous.
// The block takes one word per clock cycle while no result word is stalled, and
// keeps no state between words. The edge crossing dividers and the length
// square root are each pipelined one result bit per stage. A front register
// classifies the ray, a two-word queue decouples it from the arithmetic
// pipeline, and the whole back end holds while a result waits.
module ray_cell_travel_time #(
  parameter int unsigned COORD_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // slowness, cell_x_low, cell_y_low, cell_x_high, cell_y_high,
  // source_x, source_y, receiver_x, receiver_y
  input  logic [((rcct_pkg::SLOW_BITS + 8*COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // travel_time
  output logic [rcct_pkg::TIME_BITS-1:0] m_axis_tdata,
  // status
  output logic [rcct_pkg::STAT_BITS-1:0] m_axis_tuser
);
  import rcct_pkg::*;

  localparam int unsigned DATA_W = ((SLOW_BITS + 8*COORD_BITS + 7) / 8) * 8;
  localparam int unsigned Q_W    = DATA_W + $bits(front_ctl_t);

  logic              fr_valid, fr_ready;
  logic [DATA_W-1:0] fr_data;
  front_ctl_t        fr_ctl;
  logic              q_valid, q_pop;
  logic [Q_W-1:0]    q_data;

  rcct_front #(
    .COORD_BITS (COORD_BITS),
    .DATA_W     (DATA_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_data_o  (fr_data),
    .out_ctl_o   (fr_ctl)
  );

  rcct_fifo #(
    .WIDTH (Q_W)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_data_i  ({fr_ctl, fr_data}),
    .rd_valid_o (q_valid),
    .rd_pop_i   (q_pop),
    .rd_data_o  (q_data)
  );

  rcct_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .DATA_W     (DATA_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (q_valid),
    .in_pop_o     (q_pop),
    .in_data_i    (q_data[DATA_W-1:0]),
    .in_ctl_i     (q_data[Q_W-1:DATA_W]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_time_o   (m_axis_tdata),
    .out_status_o (m_axis_tuser)
  );

endmodule

// ----- hdl/rcct_front.sv -----
// Front end: input register, bounding box test and ray classification.
module rcct_front #(
  parameter int unsigned COORD_BITS = 32,
  parameter int unsigned DATA_W     = 288
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [DATA_W-1:0]   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DATA_W-1:0]   out_data_o,
  output rcct_pkg::front_ctl_t out_ctl_o
);
  import rcct_pkg::*;

  localparam int unsigned CB = COORD_BITS;

  logic              valid_q, valid_d;
  logic [DATA_W-1:0] data_q;
  front_ctl_t        ctl_q, ctl_d;

  logic signed [CB-1:0] cxl, cyl, cxh, cyh, sx, sy, rx, ry;
  logic signed [CB-1:0] bxl, bxh, byl, byh;

  // Unpack the coordinate fields of the incoming word
  always_comb begin
    cxl = $signed(in_data_i[SLOW_BITS + 0*CB +: CB]);
    cyl = $signed(in_data_i[SLOW_BITS + 1*CB +: CB]);
    cxh = $signed(in_data_i[SLOW_BITS + 2*CB +: CB]);
    cyh = $signed(in_data_i[SLOW_BITS + 3*CB +: CB]);
    sx  = $signed(in_data_i[SLOW_BITS + 4*CB +: CB]);
    sy  = $signed(in_data_i[SLOW_BITS + 5*CB +: CB]);
    rx  = $signed(in_data_i[SLOW_BITS + 6*CB +: CB]);
    ry  = $signed(in_data_i[SLOW_BITS + 7*CB +: CB]);
    bxl = (sx < rx) ? sx : rx;
    bxh = (sx < rx) ? rx : sx;
    byl = (sy < ry) ? sy : ry;
    byh = (sy < ry) ? ry : sy;
  end

  // Classify the ray and test the cell against its box
  always_comb begin
    ctl_d.outside = (cxh < bxl) || (cxl > bxh) || (cyh < byl) || (cyl > byh);
    priority if (rx == sx) begin
      ctl_d.kind = KIND_VERT;
    end else if (ry == sy) begin
      ctl_d.kind = KIND_HORZ;
    end else begin
      ctl_d.kind = KIND_SLOPE;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the word until the queue takes it
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
      ctl_q  <= ctl_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_ctl_o   = ctl_q;

endmodule

// ----- hdl/rcct_fifo.sv -----
// Two-entry queue between front end and back end.
module rcct_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_pop_i,
  output logic [WIDTH-1:0] rd_data_o
);
  import rcct_pkg::*;

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             push, pop;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_pop_i && rd_valid_o;
  assign rd_data_o  = mem[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ----- hdl/rcct_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module rcct_div #(
  parameter int unsigned NUM_W = 66,
  parameter int unsigned DEN_W = 33,
  parameter int unsigned QUO_W = 33
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);
  import rcct_pkg::*;

  logic [NUM_W-1:0] rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  logic [NUM_W-1:0] rem_in [QUO_W];
  logic [DEN_W-1:0] den_in [QUO_W];
  logic [QUO_W-1:0] quo_in [QUO_W];
  logic [NUM_W-1:0] rem_d  [QUO_W];
  logic [QUO_W-1:0] quo_d  [QUO_W];

  // Each stage tries the divisor shifted to its quotient bit
  always_comb begin
    logic [NUM_W-1:0] trial;
    for (int i = 0; i < QUO_W; i++) begin
      if (i == 0) begin
        rem_in[i] = num_i;
        den_in[i] = den_i;
        quo_in[i] = '0;
      end else begin
        rem_in[i] = rem_q[i-1];
        den_in[i] = den_q[i-1];
        quo_in[i] = quo_q[i-1];
      end
      trial = NUM_W'(den_in[i]) << (QUO_W - 1 - i);
      if (rem_in[i] >= trial) begin
        rem_d[i] = rem_in[i] - trial;
        quo_d[i] = {quo_in[i][QUO_W-2:0], 1'b1};
      end else begin
        rem_d[i] = rem_in[i];
        quo_d[i] = {quo_in[i][QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < QUO_W; i++) begin
        rem_q[i] <= rem_d[i];
        den_q[i] <= den_in[i];
        quo_q[i] <= quo_d[i];
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

// ----- hdl/rcct_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module rcct_sqrt #(
  parameter int unsigned RES_W = 33
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [2*RES_W-1:0] rad_i,
  output logic [RES_W-1:0]   res_o,
  output logic [RES_W+1:0]   rem_o
);
  import rcct_pkg::*;

  localparam int unsigned REM_W = RES_W + 2;
  localparam int unsigned RAD_W = 2 * RES_W;

  logic [REM_W-1:0] rem_q [RES_W];
  logic [RES_W-1:0] res_q [RES_W];
  logic [RAD_W-1:0] rad_q [RES_W];

  logic [REM_W-1:0] rem_d [RES_W];
  logic [RES_W-1:0] res_d [RES_W];
  logic [RAD_W-1:0] rad_d [RES_W];

  // Bring down two radicand bits and try the next result bit
  always_comb begin
    logic [REM_W-1:0] rem_in, rem_sh, trial;
    logic [RES_W-1:0] res_in;
    logic [RAD_W-1:0] rad_in;
    for (int i = 0; i < RES_W; i++) begin
      if (i == 0) begin
        rem_in = '0;
        res_in = '0;
        rad_in = rad_i;
      end else begin
        rem_in = rem_q[i-1];
        res_in = res_q[i-1];
        rad_in = rad_q[i-1];
      end
      rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
      trial  = {res_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_d[i] = rem_sh - trial;
        res_d[i] = {res_in[RES_W-2:0], 1'b1};
      end else begin
        rem_d[i] = rem_sh;
        res_d[i] = {res_in[RES_W-2:0], 1'b0};
      end
      rad_d[i] = {rad_in[RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < RES_W; i++) begin
        rem_q[i] <= rem_d[i];
        res_q[i] <= res_d[i];
        rad_q[i] <= rad_d[i];
      end
    end
  end

  assign res_o = res_q[RES_W-1];
  assign rem_o = rem_q[RES_W-1];

endmodule

// ----- hdl/rcct_back.sv -----
// Back end: edge crossings, point selection, length and travel time.
module rcct_back #(
  parameter int unsigned COORD_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned DATA_W     = 288
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_pop_o,
  input  logic [DATA_W-1:0]                  in_data_i,
  input  rcct_pkg::front_ctl_t               in_ctl_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [rcct_pkg::TIME_BITS-1:0]     out_time_o,
  output logic [rcct_pkg::STAT_BITS-1:0]     out_status_o
);
  import rcct_pkg::*;

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned DW    = CB + 1;        // coordinate difference
  localparam int unsigned MW    = CB;            // magnitude of a difference
  localparam int unsigned NUMW  = 2 * CB + 2;    // crossing numerator
  localparam int unsigned DENW  = CB + 1;
  localparam int unsigned QW    = CB + 1;
  localparam int unsigned PW    = CB + 2;        // candidate point coordinate
  localparam int unsigned RB    = CB + 1;        // length
  localparam int unsigned TW    = RB + SLOW_BITS + 1;
  localparam int unsigned EXT_W = TW + TIME_BITS;

  typedef struct packed {
    logic [SLOW_BITS-1:0] slow;
    logic signed [CB-1:0] cxl;
    logic signed [CB-1:0] cyl;
    logic signed [CB-1:0] cxh;
    logic signed [CB-1:0] cyh;
    logic signed [CB-1:0] sx;
    logic signed [CB-1:0] sy;
    logic signed [CB-1:0] rx;
    logic signed [CB-1:0] ry;
    logic signed [CB-1:0] bxl;
    logic signed [CB-1:0] bxh;
    logic signed [CB-1:0] byl;
    logic signed [CB-1:0] byh;
    kind_e                kind;
    logic                 outside;
    logic [3:0]           neg;
    logic [3:0]           pv;
  } geo_t;

  typedef struct packed {
    logic [SLOW_BITS-1:0] slow;
    status_e              status;
  } res_t;

  function automatic logic [MW-1:0] mag_f(input logic signed [DW-1:0] v);
    logic [DW-1:0] t;
    t = v[DW-1] ? (~v + 1'b1) : v;
    return t[MW-1:0];
  endfunction

  function automatic logic signed [PW-1:0] ext_f(input logic signed [CB-1:0] v);
    return {{(PW-CB){v[CB-1]}}, v};
  endfunction

  function automatic logic signed [DW-1:0] dif_f(input logic signed [CB-1:0] a,
                                                 input logic signed [CB-1:0] b);
    return $signed({a[CB-1], a}) - $signed({b[CB-1], b});
  endfunction

  logic en;
  logic out_valid_q;

  assign en       = !out_valid_q || out_ready_i;
  assign in_pop_o = en && in_valid_i;

  // ---------------------------------------------------------------- stage A
  geo_t          a_geo_d, a_geo_q;
  logic [MW-1:0] a_nm_d [4], a_dm_d [4], a_em_d [4];
  logic [MW-1:0] a_nm_q [4], a_dm_q [4], a_em_q [4];
  logic          a_v_q;

  // Form deltas and edge offsets of the four crossings
  always_comb begin
    logic signed [DW-1:0] dx, dy;
    logic signed [DW-1:0] nn [4];
    a_geo_d.slow    = in_data_i[SLOW_BITS-1:0];
    a_geo_d.cxl     = $signed(in_data_i[SLOW_BITS + 0*CB +: CB]);
    a_geo_d.cyl     = $signed(in_data_i[SLOW_BITS + 1*CB +: CB]);
    a_geo_d.cxh     = $signed(in_data_i[SLOW_BITS + 2*CB +: CB]);
    a_geo_d.cyh     = $signed(in_data_i[SLOW_BITS + 3*CB +: CB]);
    a_geo_d.sx      = $signed(in_data_i[SLOW_BITS + 4*CB +: CB]);
    a_geo_d.sy      = $signed(in_data_i[SLOW_BITS + 5*CB +: CB]);
    a_geo_d.rx      = $signed(in_data_i[SLOW_BITS + 6*CB +: CB]);
    a_geo_d.ry      = $signed(in_data_i[SLOW_BITS + 7*CB +: CB]);
    a_geo_d.bxl     = (a_geo_d.sx < a_geo_d.rx) ? a_geo_d.sx : a_geo_d.rx;
    a_geo_d.bxh     = (a_geo_d.sx < a_geo_d.rx) ? a_geo_d.rx : a_geo_d.sx;
    a_geo_d.byl     = (a_geo_d.sy < a_geo_d.ry) ? a_geo_d.sy : a_geo_d.ry;
    a_geo_d.byh     = (a_geo_d.sy < a_geo_d.ry) ? a_geo_d.ry : a_geo_d.sy;
    a_geo_d.kind    = in_ctl_i.kind;
    a_geo_d.outside = in_ctl_i.outside;

    dx    = dif_f(a_geo_d.rx, a_geo_d.sx);
    dy    = dif_f(a_geo_d.ry, a_geo_d.sy);
    nn[0] = dif_f(a_geo_d.cxl, a_geo_d.sx);
    nn[1] = dif_f(a_geo_d.cxh, a_geo_d.sx);
    nn[2] = dif_f(a_geo_d.cyl, a_geo_d.sy);
    nn[3] = dif_f(a_geo_d.cyh, a_geo_d.sy);

    a_geo_d.pv[0] = (a_geo_d.cxl >= a_geo_d.bxl) && (a_geo_d.cxl <= a_geo_d.bxh);
    a_geo_d.pv[1] = (a_geo_d.cxh >= a_geo_d.bxl) && (a_geo_d.cxh <= a_geo_d.bxh);
    a_geo_d.pv[2] = (a_geo_d.cyl >= a_geo_d.byl) && (a_geo_d.cyl <= a_geo_d.byh);
    a_geo_d.pv[3] = (a_geo_d.cyh >= a_geo_d.byl) && (a_geo_d.cyh <= a_geo_d.byh);

    for (int k = 0; k < 4; k++) begin
      a_nm_d[k] = mag_f(nn[k]);
      if (k < 2) begin
        a_dm_d[k]      = mag_f(dy);
        a_em_d[k]      = mag_f(dx);
        a_geo_d.neg[k] = nn[k][DW-1] ^ dy[DW-1] ^ dx[DW-1];
      end else begin
        a_dm_d[k]      = mag_f(dx);
        a_em_d[k]      = mag_f(dy);
        a_geo_d.neg[k] = nn[k][DW-1] ^ dx[DW-1] ^ dy[DW-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_geo_q <= a_geo_d;
      for (int k = 0; k < 4; k++) begin
        a_nm_q[k] <= a_nm_d[k];
        a_dm_q[k] <= a_dm_d[k];
        a_em_q[k] <= a_em_d[k];
      end
    end
  end

  // ---------------------------------------------------------------- stage B
  geo_t            b_geo_q;
  logic [NUMW-1:0] b_num_q [4];
  logic [DENW-1:0] b_den_q [4];
  logic            b_v_q;

  // Doubled product plus divisor gives round to nearest on the quotient
  always_ff @(posedge clk_i) begin
    logic [2*MW-1:0] prod;
    if (en) begin
      b_geo_q <= a_geo_q;
      for (int k = 0; k < 4; k++) begin
        prod       = a_nm_q[k] * a_dm_q[k];
        b_num_q[k] <= {1'b0, prod, 1'b0} + NUMW'(a_em_q[k]);
        b_den_q[k] <= {a_em_q[k], 1'b0};
      end
    end
  end

  // --------------------------------------------------------------- dividers
  logic [QW-1:0] quo [4];

  for (genvar k = 0; k < 4; k++) begin : g_div
    rcct_div #(
      .NUM_W (NUMW),
      .DEN_W (DENW),
      .QUO_W (QW)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (b_num_q[k]),
      .den_i (b_den_q[k]),
      .quo_o (quo[k])
    );
  end

  geo_t dly_geo_q [QW];
  logic dly_v_q   [QW];

  // Carry the cell along with the division
  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_geo_q[0] <= b_geo_q;
      for (int i = 1; i < QW; i++) begin
        dly_geo_q[i] <= dly_geo_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- stage C
  logic signed [PW-1:0] c_x_d [6], c_y_d [6], c_x_q [6], c_y_q [6];
  logic [5:0]           c_keep_d, c_keep_q;
  logic [SLOW_BITS-1:0] c_slow_q;
  logic                 c_out_q, c_v_q;

  // Build the candidate points and keep those inside cell and box
  always_comb begin
    geo_t                 g;
    logic signed [PW-1:0] cr [4];
    logic [5:0]           cv;
    g = dly_geo_q[QW-1];
    for (int k = 0; k < 4; k++) begin
      logic signed [PW-1:0] st, qx;
      st    = (k < 2) ? ext_f(g.sy) : ext_f(g.sx);
      qx    = $signed({1'b0, quo[k]});
      cr[k] = g.neg[k] ? (st - qx) : (st + qx);
    end
    priority if (g.kind == KIND_VERT) begin
      c_x_d[0] = ext_f(g.rx);  c_y_d[0] = ext_f(g.ry);
      c_x_d[1] = ext_f(g.rx);  c_y_d[1] = ext_f(g.sy);
      c_x_d[2] = ext_f(g.rx);  c_y_d[2] = ext_f(g.cyl);
      c_x_d[3] = ext_f(g.rx);  c_y_d[3] = ext_f(g.cyh);
      cv = 6'b001111;
    end else if (g.kind == KIND_HORZ) begin
      c_x_d[0] = ext_f(g.rx);  c_y_d[0] = ext_f(g.ry);
      c_x_d[1] = ext_f(g.sx);  c_y_d[1] = ext_f(g.ry);
      c_x_d[2] = ext_f(g.cxl); c_y_d[2] = ext_f(g.ry);
      c_x_d[3] = ext_f(g.cxh); c_y_d[3] = ext_f(g.ry);
      cv = 6'b001111;
    end else begin
      c_x_d[0] = ext_f(g.cxl); c_y_d[0] = cr[0];
      c_x_d[1] = ext_f(g.cxh); c_y_d[1] = cr[1];
      c_x_d[2] = cr[2];        c_y_d[2] = ext_f(g.cyl);
      c_x_d[3] = cr[3];        c_y_d[3] = ext_f(g.cyh);
      cv = {2'b11, g.pv};
    end
    c_x_d[4] = ext_f(g.sx);  c_y_d[4] = ext_f(g.sy);
    c_x_d[5] = ext_f(g.rx);  c_y_d[5] = ext_f(g.ry);
    for (int i = 0; i < 6; i++) begin
      c_keep_d[i] = cv[i]
        && (c_x_d[i] >= ext_f(g.cxl)) && (c_x_d[i] <= ext_f(g.cxh))
        && (c_y_d[i] >= ext_f(g.cyl)) && (c_y_d[i] <= ext_f(g.cyh))
        && (c_x_d[i] >= ext_f(g.bxl)) && (c_x_d[i] <= ext_f(g.bxh))
        && (c_y_d[i] >= ext_f(g.byl)) && (c_y_d[i] <= ext_f(g.byh));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        c_x_q[i] <= c_x_d[i];
        c_y_q[i] <= c_y_d[i];
      end
      c_keep_q <= c_keep_d;
      c_slow_q <= dly_geo_q[QW-1].slow;
      c_out_q  <= dly_geo_q[QW-1].outside;
    end
  end

  // ---------------------------------------------------------------- stage D
  logic signed [PW-1:0] d_p0x_d, d_p0y_d, d_p1x_d, d_p1y_d;
  logic signed [PW-1:0] d_p0x_q, d_p0y_q, d_p1x_q, d_p1y_q;
  logic [2:0]           d_cnt_d, d_cnt_q;
  logic [SLOW_BITS-1:0] d_slow_q;
  logic                 d_out_q, d_v_q;

  // Drop duplicate points, count the rest and pick the first two
  always_comb begin
    logic [5:0] uniq;
    logic       dupl;
    for (int i = 0; i < 6; i++) begin
      dupl = 1'b0;
      for (int j = 0; j < i; j++) begin
        if (c_keep_q[j] && (c_x_q[j] == c_x_q[i]) && (c_y_q[j] == c_y_q[i])) begin
          dupl = 1'b1;
        end
      end
      uniq[i] = c_keep_q[i] && !dupl;
    end
    d_cnt_d = '0;
    d_p0x_d = c_x_q[0];
    d_p0y_d = c_y_q[0];
    d_p1x_d = c_x_q[1];
    d_p1y_d = c_y_q[1];
    for (int i = 0; i < 6; i++) begin
      if (uniq[i]) begin
        if (d_cnt_d == 3'd0) begin
          d_p0x_d = c_x_q[i];
          d_p0y_d = c_y_q[i];
        end else if (d_cnt_d == 3'd1) begin
          d_p1x_d = c_x_q[i];
          d_p1y_d = c_y_q[i];
        end
        d_cnt_d = d_cnt_d + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_p0x_q  <= d_p0x_d;
      d_p0y_q  <= d_p0y_d;
      d_p1x_q  <= d_p1x_d;
      d_p1y_q  <= d_p1y_d;
      d_cnt_q  <= d_cnt_d;
      d_slow_q <= c_slow_q;
      d_out_q  <= c_out_q;
    end
  end

  // ---------------------------------------------------------------- stage E
  logic [MW-1:0] e_dx_q, e_dy_q;
  res_t          e_res_d, e_res_q;
  logic          e_v_q;
  logic [PW:0]   ux, uy;

  // Take the side lengths and settle the status
  always_comb begin
    logic signed [PW:0] ddx, ddy;
    ddx = $signed({d_p1x_q[PW-1], d_p1x_q}) - $signed({d_p0x_q[PW-1], d_p0x_q});
    ddy = $signed({d_p1y_q[PW-1], d_p1y_q}) - $signed({d_p0y_q[PW-1], d_p0y_q});
    ux  = ddx[PW] ? (~ddx + 1'b1) : ddx;
    uy  = ddy[PW] ? (~ddy + 1'b1) : ddy;
    e_res_d.slow = d_slow_q;
    priority if (d_out_q) begin
      e_res_d.status = ST_MISS;
    end else if (d_cnt_q == 3'd2) begin
      e_res_d.status = ST_HIT;
    end else if (d_cnt_q > 3'd2) begin
      e_res_d.status = ST_AMBIG;
    end else begin
      e_res_d.status = ST_MISS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_dx_q  <= ux[MW-1:0];
      e_dy_q  <= uy[MW-1:0];
      e_res_q <= e_res_d;
    end
  end

  // ---------------------------------------------------------------- stage F
  logic [2*MW-1:0] f_sx2_q, f_sy2_q;
  res_t            f_res_q;
  logic            f_v_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_sx2_q <= e_dx_q * e_dx_q;
      f_sy2_q <= e_dy_q * e_dy_q;
      f_res_q <= e_res_q;
    end
  end

  // ---------------------------------------------------------------- stage G
  logic [2*MW:0] g_sum_q;
  res_t          g_res_q;
  logic          g_v_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_sum_q <= {1'b0, f_sx2_q} + {1'b0, f_sy2_q};
      g_res_q <= f_res_q;
    end
  end

  // ------------------------------------------------------------ square root
  logic [RB-1:0] sq_res;
  logic [RB+1:0] sq_rem;

  rcct_sqrt #(
    .RES_W (RB)
  ) u_sqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .rad_i ({1'b0, g_sum_q}),
    .res_o (sq_res),
    .rem_o (sq_rem)
  );

  res_t sq_res_q [RB];
  logic sq_v_q   [RB];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_res_q[0] <= g_res_q;
      for (int i = 1; i < RB; i++) begin
        sq_res_q[i] <= sq_res_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- stage R
  logic [RB-1:0] r_len_q;
  res_t          r_res_q;
  logic          r_v_q;

  // Round the root to nearest
  always_ff @(posedge clk_i) begin
    if (en) begin
      r_len_q <= (sq_rem > (RB+2)'(sq_res)) ? (sq_res + 1'b1) : sq_res;
      r_res_q <= sq_res_q[RB-1];
    end
  end

  // ---------------------------------------------------------------- stage H
  logic [TW-1:0] h_t_q;
  status_e       h_st_q;
  logic          h_v_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_t_q  <= TW'(r_len_q * r_res_q.slow) + (TW'(1) << (FRAC_BITS - 1));
      h_st_q <= r_res_q.status;
    end
  end

  // ----------------------------------------------------------- output word
  logic [TIME_BITS-1:0] out_time_q, out_time_d;
  status_e              out_st_q;

  // Scale down and saturate; only a hit carries a time
  always_comb begin
    logic [EXT_W-1:0] ext;
    logic             sat;
    ext = {{TIME_BITS{1'b0}}, h_t_q} >> FRAC_BITS;
    sat = |ext[EXT_W-1:TIME_BITS];
    if (h_st_q != ST_HIT) begin
      out_time_d = '0;
    end else if (sat) begin
      out_time_d = {TIME_BITS{1'b1}};
    end else begin
      out_time_d = ext[TIME_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_time_q <= out_time_d;
      out_st_q   <= h_st_q;
    end
  end

  // Valid bits of every stage advance together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q       <= 1'b0;
      b_v_q       <= 1'b0;
      for (int i = 0; i < QW; i++) begin
        dly_v_q[i] <= 1'b0;
      end
      c_v_q       <= 1'b0;
      d_v_q       <= 1'b0;
      e_v_q       <= 1'b0;
      f_v_q       <= 1'b0;
      g_v_q       <= 1'b0;
      for (int i = 0; i < RB; i++) begin
        sq_v_q[i] <= 1'b0;
      end
      r_v_q       <= 1'b0;
      h_v_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      a_v_q      <= in_valid_i;
      b_v_q      <= a_v_q;
      dly_v_q[0] <= b_v_q;
      for (int i = 1; i < QW; i++) begin
        dly_v_q[i] <= dly_v_q[i-1];
      end
      c_v_q     <= dly_v_q[QW-1];
      d_v_q     <= c_v_q;
      e_v_q     <= d_v_q;
      f_v_q     <= e_v_q;
      g_v_q     <= f_v_q;
      sq_v_q[0] <= g_v_q;
      for (int i = 1; i < RB; i++) begin
        sq_v_q[i] <= sq_v_q[i-1];
      end
      r_v_q       <= sq_v_q[RB-1];
      h_v_q       <= r_v_q;
      out_valid_q <= h_v_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_time_o   = out_time_q;
  assign out_status_o = out_st_q;

endmodule

// ----- hdl/rcct_checker.sv -----
// Port-level checks of the ray cell travel time block, bound to the top.
module rcct_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [rcct_pkg::TIME_BITS-1:0] m_axis_tdata,
  input logic [rcct_pkg::STAT_BITS-1:0] m_axis_tuser
);
  import rcct_pkg::*;

  // A stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result word changed");

  // Status is one of the three codes
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == ST_HIT) || (m_axis_tuser == ST_MISS)
                      || (m_axis_tuser == ST_AMBIG))
    else $error("unknown status code");

  // Only a hit carries a travel time
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_HIT) |-> (m_axis_tdata == '0))
    else $error("nonzero time without hit");

  // No result right out of reset
  a_rst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result word right after reset");

endmodule

bind ray_cell_travel_time rcct_checker u_rcct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
